>>> sv/rast_pkg.sv
package rast_pkg;

   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_SORT  = 2'd1,
      ACT_PRINT = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef struct packed {
      action_type         action;
      logic signed [15:0] rect_width;
      logic signed [15:0] rect_height;
   } req_type;

   typedef struct packed {
      logic [5:0]         entry_count;
      logic               has_entry;
      logic signed [15:0] out_width;
      logic signed [15:0] out_height;
      logic signed [31:0] out_area;
      logic               last;
   } rsp_type;

   // one table entry as held in the store
   typedef struct packed {
      logic signed [15:0] w;
      logic signed [15:0] h;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_I,
      ST_MUL_I,
      ST_AREA_I,
      ST_MUL_J,
      ST_CMP_J,
      ST_WB_I,
      ST_PR_RD,
      ST_PR_MUL,
      ST_PR_OUT
   } state_type;

endpackage

>>> sv/rectangle_area_sort_table_core.sv
// Rectangle area sort table. Holds up to DEPTH signed rectangles in a one-write,
// one-read store. An item is taken when start is high and busy is low. Add and
// clear leave busy low, so adds can come every cycle; an add to a full table is
// dropped. Print walks the table in stored order and sends one result per entry,
// each through the read, multiply and send states, the last one marked by last;
// an empty table gives a single result with has_entry low. Sort does an in-place
// exchange sort on area before printing: each entry i is held in a register and
// compared against every later entry j, each pair passing through read and
// multiply, then compare and write, while each i adds states to load, take its
// area and write back; the print starts when the sort is done. The single store
// read port and the one shared multiplier set this step order. Results are
// strobed for one cycle on rsp_strobe and cannot be held off. The store has no
// reset; only written entries are read.
module rectangle_area_sort_table_core #(
   parameter int DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rast_pkg::req_type req_item,
   output logic              rsp_strobe,
   output rast_pkg::rsp_type rsp_item
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // table store
   rast_pkg::entry_type mem [DEPTH];
   rast_pkg::entry_type rd_data_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   rast_pkg::entry_type wr_data;

   // sequencer state
   rast_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [IDX_W-1:0]    i_ff, i_in;
   logic [IDX_W-1:0]    j_ff, j_in;
   logic [IDX_W-1:0]    k_ff, k_in;
   rast_pkg::entry_type cur_ff, cur_in;     // entry held for position i
   logic signed [31:0]  cur_area_ff, cur_area_in;
   rast_pkg::entry_type tmp_ff, tmp_in;     // entry under compare / print
   logic                rsp_strobe_ff, rsp_strobe_in;
   rast_pkg::rsp_type   rsp_ff, rsp_in;
   logic signed [31:0]  product;
   logic                go_print;
   logic                pr_last;

   rast_mul u_mul (
      .clock      (clock),
      .a          (rd_data_ff.w),
      .b          (rd_data_ff.h),
      .product_ff (product)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rast_pkg::ST_IDLE;
         fill_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      cur_ff      <= cur_in;
      cur_area_ff <= cur_area_in;
      tmp_ff      <= tmp_in;
      rsp_ff      <= rsp_in;
   end

   assign pr_last = ((CNT_W'(k_ff) + CNT_W'(1)) == fill_ff);

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      cur_in        = cur_ff;
      cur_area_in   = cur_area_ff;
      tmp_in        = tmp_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = i_ff;
      wr_data       = cur_ff;
      rd_addr       = '0;
      go_print      = 1'b0;

      case (state_ff)
         rast_pkg::ST_IDLE: begin
            if (start) begin
               case (req_item.action)
                  rast_pkg::ACT_ADD: begin
                     if (fill_ff < CNT_W'(DEPTH)) begin
                        wr_en     = 1'b1;
                        wr_addr   = IDX_W'(fill_ff);
                        wr_data.w = req_item.rect_width;
                        wr_data.h = req_item.rect_height;
                        fill_in   = fill_ff + CNT_W'(1);
                     end
                  end
                  rast_pkg::ACT_SORT: begin
                     if (fill_ff > CNT_W'(1)) begin
                        i_in     = '0;
                        state_in = rast_pkg::ST_RD_I;
                     end else begin
                        go_print = 1'b1;
                     end
                  end
                  rast_pkg::ACT_PRINT: go_print = 1'b1;
                  rast_pkg::ACT_CLEAR: fill_in = '0;
                  default: ;
               endcase
            end
            if (go_print) begin
               if (fill_ff == '0) begin
                  // empty table: one result, no rectangle
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '0;
                  rsp_in.last   = 1'b1;
               end else begin
                  k_in     = '0;
                  state_in = rast_pkg::ST_PR_RD;
               end
            end
         end
         rast_pkg::ST_RD_I: begin
            rd_addr  = i_ff;
            state_in = rast_pkg::ST_MUL_I;
         end
         rast_pkg::ST_MUL_I: begin
            cur_in   = rd_data_ff;
            j_in     = i_ff + IDX_W'(1);
            state_in = rast_pkg::ST_AREA_I;
         end
         rast_pkg::ST_AREA_I: begin
            cur_area_in = product;
            rd_addr     = j_ff;
            state_in    = rast_pkg::ST_MUL_J;
         end
         rast_pkg::ST_MUL_J: begin
            tmp_in   = rd_data_ff;
            state_in = rast_pkg::ST_CMP_J;
         end
         rast_pkg::ST_CMP_J: begin
            // swap: held entry goes to j, entry j becomes the held one
            if (cur_area_ff > product) begin
               wr_en       = 1'b1;
               wr_addr     = j_ff;
               wr_data     = cur_ff;
               cur_in      = tmp_ff;
               cur_area_in = product;
            end
            if ((CNT_W'(j_ff) + CNT_W'(1)) < fill_ff) begin
               j_in     = j_ff + IDX_W'(1);
               rd_addr  = j_ff + IDX_W'(1);
               state_in = rast_pkg::ST_MUL_J;
            end else begin
               state_in = rast_pkg::ST_WB_I;
            end
         end
         rast_pkg::ST_WB_I: begin
            wr_en   = 1'b1;
            wr_addr = i_ff;
            wr_data = cur_ff;
            if ((CNT_W'(i_ff) + CNT_W'(2)) < fill_ff) begin
               i_in     = i_ff + IDX_W'(1);
               state_in = rast_pkg::ST_RD_I;
            end else begin
               k_in     = '0;
               state_in = rast_pkg::ST_PR_RD;
            end
         end
         rast_pkg::ST_PR_RD: begin
            rd_addr  = k_ff;
            state_in = rast_pkg::ST_PR_MUL;
         end
         rast_pkg::ST_PR_MUL: begin
            tmp_in   = rd_data_ff;
            state_in = rast_pkg::ST_PR_OUT;
         end
         rast_pkg::ST_PR_OUT: begin
            rsp_strobe_in      = 1'b1;
            rsp_in.entry_count = 6'(fill_ff);
            rsp_in.has_entry   = 1'b1;
            rsp_in.out_width   = tmp_ff.w;
            rsp_in.out_height  = tmp_ff.h;
            rsp_in.out_area    = product;
            rsp_in.last        = pr_last;
            if (pr_last) begin
               state_in = rast_pkg::ST_IDLE;
            end else begin
               k_in     = k_ff + IDX_W'(1);
               state_in = rast_pkg::ST_PR_RD;
            end
         end
         default: state_in = rast_pkg::ST_IDLE;
      endcase
   end

   assign busy       = (state_ff != rast_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

>>> sv/rast_mul.sv
// shared signed 16x16 multiplier, product registered
module rast_mul (
   input  logic               clock,
   input  logic signed [15:0] a,
   input  logic signed [15:0] b,
   output logic signed [31:0] product_ff
);

   logic signed [31:0] product_in;

   assign product_in = 32'(a) * 32'(b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

>>> sv/rast_checker.sv
module rast_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input rast_pkg::req_type req_item,
   input logic              rsp_strobe,
   input rast_pkg::rsp_type rsp_item
);

   // empty-table result is always the only one of its run
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.has_entry |-> rsp_item.last && rsp_item.entry_count == 6'd0)
      else $error("empty result malformed");

   // area matches the rectangle it travels with
   a_area: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.has_entry |->
         rsp_item.out_area == rsp_item.out_width * rsp_item.out_height)
      else $error("area mismatch");

   // more results of a run pending: block stays busy
   a_busy_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |-> busy)
      else $error("idle in the middle of a print run");

   // add and clear never make the block busy
   a_add_clear_fast: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_item.action == rast_pkg::ACT_ADD ||
                         req_item.action == rast_pkg::ACT_CLEAR) |=> !busy)
      else $error("add or clear stalled the block");

endmodule

bind rectangle_area_sort_table_core rast_checker u_rast_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

>>> tb/rectangle_area_sort_table_core_test.sv
module rectangle_area_sort_table_core_test;

   localparam int TAB_DEPTH    = 32;
   localparam int CLK_PERIOD   = 8;
   localparam int RESET_CYCLES = 4;
   localparam int ITEM_GOAL    = 230;
   // a full sort accepts no item and sends no row until it prints; leave lots of room
   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 20;
   localparam int SHOW_LIMIT   = 10;
   localparam int DIR_STEPS    = 22;

   // row sent for a print or sort of an empty table
   localparam rast_pkg::rsp_type EMPTY_ROW =
      '{6'd0, 1'b0, 16'sh0000, 16'sh0000, 32'sh0, 1'b1};
   localparam rast_pkg::rsp_type NO_ROW    = '0;

   // one directed step: the item, and where it is obvious, the single row it must give
   typedef struct packed {
      rast_pkg::req_type req;
      logic              typed;
      rast_pkg::rsp_type row;
   } step_type;

   logic              clock    = 1'b0;
   logic              reset    = 1'b1;
   logic              start    = 1'b0;
   rast_pkg::req_type req_item = '0;
   logic              busy;
   logic              rsp_strobe;
   rast_pkg::rsp_type rsp_item;

   // shadow copy of the rectangle table
   logic signed [15:0] tab_w [TAB_DEPTH];
   logic signed [15:0] tab_h [TAB_DEPTH];
   int                 tab_fill = 0;

   rast_pkg::rsp_type fresh_rows [$];   // rows produced by the item just taken
   rast_pkg::rsp_type rows_due [$];     // rows still to come out of the block, oldest first
   rast_pkg::rsp_type row_want;

   int error_count  = 0;
   int items_sent   = 0;
   int idle_pct     = 9;
   int stall_cycles = 0;

   // Directed part. Typed rows: empty table after reset and after a clear,
   // extreme corners of the multiplier (most negative squared, max times min).
   // Everything else is left to the shadow table. Covers every action, ties in
   // area, negative areas, and clear with junk in the rectangle fields.
   step_type dir_table [DIR_STEPS] = '{
      '{'{rast_pkg::ACT_PRINT, 16'sh0000, 16'sh0000}, 1'b1, EMPTY_ROW},
      '{'{rast_pkg::ACT_SORT,  16'sh0000, 16'sh0000}, 1'b1, EMPTY_ROW},
      '{'{rast_pkg::ACT_ADD,   16'sh8000, 16'sh8000}, 1'b0, NO_ROW},
      '{'{rast_pkg::ACT_PRINT, 16'sh0000, 16'sh0000}, 1'b1,
        '{6'd1, 1'b1, 16'sh8000, 16'sh8000, 32'sh4000_0000, 1'b1}},
      '{'{rast_pkg::ACT_CLEAR, 16'shFFFF, 16'shFFFF}, 1'b0, NO_ROW},
      '{'{rast_pkg::ACT_ADD,   16'sh7FFF, 16'sh8000}, 1'b0, NO_ROW},
      '{'{rast_pkg::ACT_PRINT, 16'shFFFF, 16'shFFFF}, 1'b1,
        '{6'd1, 1'b1, 16'sh7FFF, 16'sh8000, 32'shC000_8000, 1'b1}},
      '{'{rast_pkg::ACT_ADD,   16'sh7FFF, 16'sh7FFF}, 1'b0, NO_ROW},
      '{'{rast_pkg::ACT_ADD,   16'sh0000, 16'sh0000}, 1'b0, NO_ROW},
      '{'{rast_pkg::ACT_ADD,   16'shFFFF, 16'sh0001}, 1'b0, NO_ROW},
      '{'{rast_pkg::ACT_ADD,   16'sh5555, 16'shAAAA}, 1'b0, NO_ROW},
      '{'{rast_pkg::ACT_ADD,   16'shAAAA, 16'sh5555}, 1'b0, NO_ROW},
      '{'{rast_pkg::ACT_ADD,   16'sh0002, 16'sh0003}, 1'b0, NO_ROW},
      '{'{rast_pkg::ACT_ADD,   16'sh0003, 16'sh0002}, 1'b0, NO_ROW},
      '{'{rast_pkg::ACT_PRINT, 16'sh0000, 16'sh0000}, 1'b0, NO_ROW},
      '{'{rast_pkg::ACT_SORT,  16'sh0000, 16'sh0000}, 1'b0, NO_ROW},
      '{'{rast_pkg::ACT_PRINT, 16'sh0000, 16'sh0000}, 1'b0, NO_ROW},
      '{'{rast_pkg::ACT_CLEAR, 16'sh5A5A, 16'shA5A5}, 1'b0, NO_ROW},
      '{'{rast_pkg::ACT_SORT,  16'shFFFF, 16'sh0000}, 1'b1, EMPTY_ROW},
      '{'{rast_pkg::ACT_ADD,   16'shFFFE, 16'shFFFD}, 1'b0, NO_ROW},
      '{'{rast_pkg::ACT_ADD,   16'sh0001, 16'sh0001}, 1'b0, NO_ROW},
      '{'{rast_pkg::ACT_SORT,  16'sh0000, 16'sh0000}, 1'b0, NO_ROW}
   };

   rectangle_area_sort_table_core #(
      .DEPTH(TAB_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // signed area, wide enough that the compare never overflows
   function automatic longint rect_area(int k);
      return longint'(tab_w[k]) * longint'(tab_h[k]);
   endfunction

   // Apply one item to the shadow table; rows it causes land in fresh_rows.
   function automatic void apply_action(rast_pkg::req_type it);
      int                 i;
      int                 j;
      int                 k;
      logic signed [15:0] tw;
      logic signed [15:0] th;
      rast_pkg::rsp_type  row;
      fresh_rows = {};
      case (it.action)
         rast_pkg::ACT_ADD: begin
            // add to a full table is dropped
            if (tab_fill < TAB_DEPTH) begin
               tab_w[tab_fill] = it.rect_width;
               tab_h[tab_fill] = it.rect_height;
               tab_fill++;
            end
         end
         rast_pkg::ACT_CLEAR: begin
            tab_fill = 0;
         end
         default: begin
            // exchange sort: i ascending, every later j, swap when area(i) > area(j)
            if (it.action == rast_pkg::ACT_SORT) begin
               for (i = 0; i < tab_fill; i++) begin
                  for (j = i + 1; j < tab_fill; j++) begin
                     if (rect_area(i) > rect_area(j)) begin
                        tw = tab_w[i];
                        th = tab_h[i];
                        tab_w[i] = tab_w[j];
                        tab_h[i] = tab_h[j];
                        tab_w[j] = tw;
                        tab_h[j] = th;
                     end
                  end
               end
            end
            if (tab_fill == 0) begin
               fresh_rows = {fresh_rows, EMPTY_ROW};
            end else begin
               for (k = 0; k < tab_fill; k++) begin
                  row.entry_count = 6'(tab_fill);
                  row.has_entry   = 1'b1;
                  row.out_width   = tab_w[k];
                  row.out_height  = tab_h[k];
                  row.out_area    = 32'(rect_area(k));
                  row.last        = (k == tab_fill - 1);
                  fresh_rows = {fresh_rows, row};
               end
            end
         end
      endcase
   endfunction

   // Dimension picker: corners often, tiny values for area ties, else anything.
   function automatic logic signed [15:0] pick_dim();
      logic signed [15:0] v;
      case ($urandom_range(0, 7))
         0: v = 16'sh8000;
         1: v = 16'sh7FFF;
         2: v = 16'sh0000;
         3, 4: begin
            v = 16'($urandom_range(0, 8));
            v = v - 16'sd4;
         end
         default: v = 16'($urandom());
      endcase
      return v;
   endfunction

   // Present one item, hold it until taken, then queue up what it must produce.
   // The item is taken at the first edge that sees start high and busy low.
   task automatic post_item(input rast_pkg::req_type it, input logic typed,
                            input rast_pkg::rsp_type typed_row);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      // an add to a full table does nothing, so it is not counted
      if (!(it.action == rast_pkg::ACT_ADD && tab_fill >= TAB_DEPTH)) items_sent++;
      apply_action(it);
      if (typed) begin
         rows_due = {rows_due, typed_row};
      end else begin
         rows_due = {rows_due, fresh_rows};
      end
   endtask

   task automatic send(input rast_pkg::req_type it);
      post_item(it, 1'b0, NO_ROW);
   endtask

   // Result checker: every strobed row must match the oldest row due.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (rows_due.size() == 0) begin
            error_count++;
            if (error_count <= SHOW_LIMIT)
               $display("unexpected row: count=%0d has=%0b w=%0d h=%0d area=%0d last=%0b",
                        rsp_item.entry_count, rsp_item.has_entry, rsp_item.out_width,
                        rsp_item.out_height, rsp_item.out_area, rsp_item.last);
         end else begin
            row_want = rows_due.pop_front();
            if (rsp_item.entry_count !== row_want.entry_count ||
                rsp_item.has_entry   !== row_want.has_entry   ||
                rsp_item.out_width   !== row_want.out_width   ||
                rsp_item.out_height  !== row_want.out_height  ||
                rsp_item.out_area    !== row_want.out_area    ||
                rsp_item.last        !== row_want.last) begin
               error_count++;
               if (error_count <= SHOW_LIMIT) begin
                  $display("row mismatch: exp count=%0d has=%0b w=%0d h=%0d area=%0d last=%0b",
                           row_want.entry_count, row_want.has_entry, row_want.out_width,
                           row_want.out_height, row_want.out_area, row_want.last);
                  $display("              got count=%0d has=%0b w=%0d h=%0d area=%0d last=%0b",
                           rsp_item.entry_count, rsp_item.has_entry, rsp_item.out_width,
                           rsp_item.out_height, rsp_item.out_area, rsp_item.last);
               end
            end
         end
      end
   end

   // Watchdog: counts cycles in which neither an item nor a row is taken.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe === 1'b1) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   // Main sequence.
   initial begin
      int  batch;
      int  n;
      int  k;
      logic full_run;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[s]) post_item(dir_table[s].req, dir_table[s].typed, dir_table[s].row);

      // Random part: mostly well-formed batches (clear, a few adds, sort or print),
      // sprinkled with stray items. The first batch, and now and then another,
      // fills the table and keeps adding so that full-table drops get exercised.
      for (batch = 0; items_sent < ITEM_GOAL; batch++) begin
         // one long stretch with no gaps on the request side
         idle_pct = (batch >= 10 && batch < 16) ? 0 : 9;
         full_run = (batch == 0) || ($urandom_range(0, 11) == 0);
         n = full_run ? TAB_DEPTH + $urandom_range(1, 3) : $urandom_range(0, 8);
         if (full_run || $urandom_range(0, 3) != 0)
            send(rast_pkg::req_type'{rast_pkg::ACT_CLEAR, 16'($urandom()), 16'($urandom())});
         for (k = 0; k < n; k++) begin
            if (!full_run && $urandom_range(0, 7) == 0)
               send(rast_pkg::req_type'{rast_pkg::action_type'($urandom_range(0, 3)),
                                        16'($urandom()), 16'($urandom())});
            else
               send(rast_pkg::req_type'{rast_pkg::ACT_ADD, pick_dim(), pick_dim()});
         end
         if ($urandom_range(0, 9) < 6) begin
            send(rast_pkg::req_type'{rast_pkg::ACT_SORT, 16'($urandom()), 16'($urandom())});
            // printing right after a sort must show the sorted order again
            if ($urandom_range(0, 2) == 0)
               send(rast_pkg::req_type'{rast_pkg::ACT_PRINT,
                                        16'($urandom()), 16'($urandom())});
         end else begin
            send(rast_pkg::req_type'{rast_pkg::ACT_PRINT, 16'($urandom()), 16'($urandom())});
         end
      end
      start <= 1'b0;

      // drain: wait for every row due, then a little longer for strays
      while (rows_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      error_count += rows_due.size();

      if (error_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
